@@ hdl/obbpq_pkg.sv @@
// ----------------------------------------------------------------------------
// obbpq_pkg
// Shared types and constants for the oriented box point query and grow unit.
// ----------------------------------------------------------------------------
package obbpq_pkg;

    // field widths
    localparam int COORD_W   = 32;               // Q16.16 coordinates
    localparam int HALF_W    = 31;               // unsigned half extents
    localparam int AXIS_W    = 16;               // Q1.14 axis components
    localparam int AXIS_FRAC = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // dot product unit widths
    localparam int DOT_W     = 36;               // widest operand (half gap)
    localparam int PROD_W    = DOT_W + AXIS_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DOT_RES_W = ACC_W - AXIS_FRAC;

    // working widths
    localparam int DIFF_W  = COORD_W + 1;        // point minus center
    localparam int PROJ_W  = 36;                 // local projection
    localparam int NEAR_W  = 36;                 // nearest point, unsaturated
    localparam int GAP_W   = 36;                 // half gap
    localparam int CSUM_W  = COORD_W + 5;        // center plus half gap
    localparam int HSUM_W  = DOT_RES_W + 1;      // extent plus local gap

    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = 1 + 4 * COORD_W + 2 * HALF_W + 1;

    localparam logic [AXIS_W-1:0] AXIS_COS_RST = AXIS_W'(16384);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_COS    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_SIN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_GROW_EN     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PI,
        ST_PJ,
        ST_CLAMP,
        ST_NX,
        ST_NY,
        ST_GAP,
        ST_GI,
        ST_GJ,
        ST_UPD,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DOT_PI,
        DOT_PJ,
        DOT_NX,
        DOT_NY,
        DOT_GI,
        DOT_GJ
    } dot_op_t;

    typedef struct packed {
        logic    accept;
        dot_op_t dot_op;
        logic    ld_pi;
        logic    ld_pj;
        logic    ld_clamp;
        logic    ld_offx;
        logic    ld_offy;
        logic    ld_gap;
        logic    ld_gi;
        logic    ld_gj;
        logic    ld_upd;
        logic    ld_out;
    } cmd_t;

    typedef struct packed {
        logic grow;
        logic out_busy;
    } status_t;

endpackage

@@ hdl/obbpq_dot.sv @@
// ----------------------------------------------------------------------------
// obbpq_dot
// Shared rotation unit: a*cos +/- b*sin, floored by the axis fraction bits.
// ----------------------------------------------------------------------------
module obbpq_dot (
    input  logic signed [obbpq_pkg::DOT_W-1:0]     op_a,
    input  logic signed [obbpq_pkg::DOT_W-1:0]     op_b,
    input  logic signed [obbpq_pkg::AXIS_W-1:0]    cos_v,
    input  logic signed [obbpq_pkg::AXIS_W-1:0]    sin_v,
    input  logic                                   sub,
    output logic signed [obbpq_pkg::DOT_RES_W-1:0] res
);

    logic signed [obbpq_pkg::PROD_W-1:0] prod_c;
    logic signed [obbpq_pkg::PROD_W-1:0] prod_s;
    logic signed [obbpq_pkg::ACC_W-1:0]  acc;

    assign prod_c = obbpq_pkg::PROD_W'(op_a) * obbpq_pkg::PROD_W'(cos_v);
    assign prod_s = obbpq_pkg::PROD_W'(op_b) * obbpq_pkg::PROD_W'(sin_v);

    always_comb begin
        if (sub) begin
            acc = obbpq_pkg::ACC_W'(prod_c) - obbpq_pkg::ACC_W'(prod_s);
        end else begin
            acc = obbpq_pkg::ACC_W'(prod_c) + obbpq_pkg::ACC_W'(prod_s);
        end
    end

    // dropping the low bits is a floor shift
    assign res = acc[obbpq_pkg::ACC_W-1:obbpq_pkg::AXIS_FRAC];

endmodule

@@ hdl/obbpq_dpath.sv @@
// ----------------------------------------------------------------------------
// obbpq_dpath
// Datapath: box state, configuration registers, working registers for one
// point and the output register.
// ----------------------------------------------------------------------------
module obbpq_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [obbpq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [obbpq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [obbpq_pkg::IN_DATA_W-1:0]       s_tdata,
    input  obbpq_pkg::cmd_t                       cmd,
    output obbpq_pkg::status_t                    status,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [obbpq_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int CW = obbpq_pkg::COORD_W;
    localparam int HW = obbpq_pkg::HALF_W;

    // configuration and box state
    logic signed [CW-1:0]                  cx_reg, cy_reg;
    logic [HW-1:0]                         hw_reg, hh_reg;
    logic signed [obbpq_pkg::AXIS_W-1:0]   cos_reg, sin_reg;
    logic                                  grow_reg;

    // per point working registers
    logic signed [CW-1:0]                     px_reg, py_reg;
    logic signed [obbpq_pkg::DIFF_W-1:0]      dx_reg, dy_reg;
    logic signed [obbpq_pkg::PROJ_W-1:0]      pi_reg, pj_reg;
    logic signed [CW-1:0]                     ni_reg, nj_reg;
    logic                                     inside_reg;
    logic signed [obbpq_pkg::NEAR_W-1:0]      offx_reg, offy_reg;
    logic signed [obbpq_pkg::NEAR_W-1:0]      nx_reg, ny_reg;
    logic signed [obbpq_pkg::GAP_W-1:0]       gx_reg, gy_reg;
    logic signed [obbpq_pkg::DOT_RES_W-1:0]   gi_reg, gj_reg;
    logic                                     sat_reg;
    logic                                     m_tvalid_reg;
    logic [obbpq_pkg::OUT_DATA_W-1:0]         m_tdata_reg;

    logic signed [CW-1:0] in_px, in_py;
    assign in_px = s_tdata[CW-1:0];
    assign in_py = s_tdata[2*CW-1:CW];

    // rotation unit operand select
    logic signed [obbpq_pkg::DOT_W-1:0]     op_a, op_b;
    logic                                   op_sub;
    logic signed [obbpq_pkg::DOT_RES_W-1:0] dot_res;

    always_comb begin
        case (cmd.dot_op)
            obbpq_pkg::DOT_PI: begin
                op_a = obbpq_pkg::DOT_W'(dx_reg); op_b = obbpq_pkg::DOT_W'(dy_reg);
                op_sub = 1'b0;
            end
            obbpq_pkg::DOT_PJ: begin
                op_a = obbpq_pkg::DOT_W'(dy_reg); op_b = obbpq_pkg::DOT_W'(dx_reg);
                op_sub = 1'b1;
            end
            obbpq_pkg::DOT_NX: begin
                op_a = obbpq_pkg::DOT_W'(ni_reg); op_b = obbpq_pkg::DOT_W'(nj_reg);
                op_sub = 1'b1;
            end
            obbpq_pkg::DOT_NY: begin
                op_a = obbpq_pkg::DOT_W'(nj_reg); op_b = obbpq_pkg::DOT_W'(ni_reg);
                op_sub = 1'b0;
            end
            obbpq_pkg::DOT_GI: begin
                op_a = gx_reg; op_b = gy_reg;
                op_sub = 1'b0;
            end
            obbpq_pkg::DOT_GJ: begin
                op_a = gy_reg; op_b = gx_reg;
                op_sub = 1'b1;
            end
            default: begin
                op_a = '0; op_b = '0;
                op_sub = 1'b0;
            end
        endcase
    end

    obbpq_dot u_dot (
        .op_a  (op_a),
        .op_b  (op_b),
        .cos_v (cos_reg),
        .sin_v (sin_reg),
        .sub   (op_sub),
        .res   (dot_res)
    );

    // clamp of the local coordinates to the half extents
    logic signed [obbpq_pkg::PROJ_W-1:0] hw_pos, hw_neg, hh_pos, hh_neg;
    logic                                pi_lo, pi_hi, pj_lo, pj_hi;
    logic signed [CW-1:0]                ni_c, nj_c;

    always_comb begin
        hw_pos = obbpq_pkg::PROJ_W'(hw_reg);
        hh_pos = obbpq_pkg::PROJ_W'(hh_reg);
        hw_neg = -hw_pos;
        hh_neg = -hh_pos;
        pi_lo  = pi_reg < hw_neg;
        pi_hi  = pi_reg > hw_pos;
        pj_lo  = pj_reg < hh_neg;
        pj_hi  = pj_reg > hh_pos;
        if (pi_lo) begin
            ni_c = hw_neg[CW-1:0];
        end else if (pi_hi) begin
            ni_c = hw_pos[CW-1:0];
        end else begin
            ni_c = pi_reg[CW-1:0];
        end
        if (pj_lo) begin
            nj_c = hh_neg[CW-1:0];
        end else if (pj_hi) begin
            nj_c = hh_pos[CW-1:0];
        end else begin
            nj_c = pj_reg[CW-1:0];
        end
    end

    // nearest point and half gap
    logic signed [obbpq_pkg::NEAR_W-1:0] nx_c, ny_c;
    logic signed [obbpq_pkg::GAP_W:0]    diffx, diffy;

    always_comb begin
        nx_c  = obbpq_pkg::NEAR_W'(cx_reg) + offx_reg;
        ny_c  = obbpq_pkg::NEAR_W'(cy_reg) + offy_reg;
        diffx = (obbpq_pkg::GAP_W + 1)'(px_reg) - (obbpq_pkg::GAP_W + 1)'(nx_c);
        diffy = (obbpq_pkg::GAP_W + 1)'(py_reg) - (obbpq_pkg::GAP_W + 1)'(ny_c);
    end

    // box update with saturation
    logic signed [obbpq_pkg::CSUM_W-1:0] csum_x, csum_y;
    logic [obbpq_pkg::DOT_RES_W-1:0]     gi_mag, gj_mag;
    logic [obbpq_pkg::HSUM_W-1:0]        hsum_w, hsum_h;
    logic                                ovf_cx, ovf_cy, ovf_hw, ovf_hh;
    logic signed [CW-1:0]                cx_new, cy_new;
    logic [HW-1:0]                       hw_new, hh_new;

    always_comb begin
        csum_x = obbpq_pkg::CSUM_W'(cx_reg) + obbpq_pkg::CSUM_W'(gx_reg);
        csum_y = obbpq_pkg::CSUM_W'(cy_reg) + obbpq_pkg::CSUM_W'(gy_reg);
        // in range when the sign bit and all bits above it agree
        ovf_cx = !((&csum_x[obbpq_pkg::CSUM_W-1:CW-1]) || !(|csum_x[obbpq_pkg::CSUM_W-1:CW-1]));
        ovf_cy = !((&csum_y[obbpq_pkg::CSUM_W-1:CW-1]) || !(|csum_y[obbpq_pkg::CSUM_W-1:CW-1]));
        if (!ovf_cx) begin
            cx_new = csum_x[CW-1:0];
        end else if (csum_x[obbpq_pkg::CSUM_W-1]) begin
            cx_new = {1'b1, {(CW-1){1'b0}}};
        end else begin
            cx_new = {1'b0, {(CW-1){1'b1}}};
        end
        if (!ovf_cy) begin
            cy_new = csum_y[CW-1:0];
        end else if (csum_y[obbpq_pkg::CSUM_W-1]) begin
            cy_new = {1'b1, {(CW-1){1'b0}}};
        end else begin
            cy_new = {1'b0, {(CW-1){1'b1}}};
        end

        gi_mag = gi_reg[obbpq_pkg::DOT_RES_W-1] ? obbpq_pkg::DOT_RES_W'(-gi_reg)
                                                : obbpq_pkg::DOT_RES_W'(gi_reg);
        gj_mag = gj_reg[obbpq_pkg::DOT_RES_W-1] ? obbpq_pkg::DOT_RES_W'(-gj_reg)
                                                : obbpq_pkg::DOT_RES_W'(gj_reg);
        hsum_w = obbpq_pkg::HSUM_W'(hw_reg) + obbpq_pkg::HSUM_W'(gi_mag);
        hsum_h = obbpq_pkg::HSUM_W'(hh_reg) + obbpq_pkg::HSUM_W'(gj_mag);
        ovf_hw = |hsum_w[obbpq_pkg::HSUM_W-1:HW];
        ovf_hh = |hsum_h[obbpq_pkg::HSUM_W-1:HW];
        hw_new = ovf_hw ? {HW{1'b1}} : hsum_w[HW-1:0];
        hh_new = ovf_hh ? {HW{1'b1}} : hsum_h[HW-1:0];
    end

    // nearest point saturated to the coordinate range
    logic signed [CW-1:0] near_x, near_y;

    always_comb begin
        if ((&nx_reg[obbpq_pkg::NEAR_W-1:CW-1]) || !(|nx_reg[obbpq_pkg::NEAR_W-1:CW-1])) begin
            near_x = nx_reg[CW-1:0];
        end else if (nx_reg[obbpq_pkg::NEAR_W-1]) begin
            near_x = {1'b1, {(CW-1){1'b0}}};
        end else begin
            near_x = {1'b0, {(CW-1){1'b1}}};
        end
        if ((&ny_reg[obbpq_pkg::NEAR_W-1:CW-1]) || !(|ny_reg[obbpq_pkg::NEAR_W-1:CW-1])) begin
            near_y = ny_reg[CW-1:0];
        end else if (ny_reg[obbpq_pkg::NEAR_W-1]) begin
            near_y = {1'b1, {(CW-1){1'b0}}};
        end else begin
            near_y = {1'b0, {(CW-1){1'b1}}};
        end
    end

    // box state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            hw_reg   <= '0;
            hh_reg   <= '0;
            cos_reg  <= obbpq_pkg::AXIS_COS_RST;
            sin_reg  <= '0;
            grow_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                obbpq_pkg::REG_CENTER_X:    cx_reg   <= cfg_wdata[CW-1:0];
                obbpq_pkg::REG_CENTER_Y:    cy_reg   <= cfg_wdata[CW-1:0];
                obbpq_pkg::REG_HALF_WIDTH:  hw_reg   <= cfg_wdata[HW-1:0];
                obbpq_pkg::REG_HALF_HEIGHT: hh_reg   <= cfg_wdata[HW-1:0];
                obbpq_pkg::REG_AXIS_COS:    cos_reg  <= cfg_wdata[obbpq_pkg::AXIS_W-1:0];
                obbpq_pkg::REG_AXIS_SIN:    sin_reg  <= cfg_wdata[obbpq_pkg::AXIS_W-1:0];
                obbpq_pkg::REG_GROW_EN:     grow_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end else if (cmd.ld_upd) begin
            cx_reg <= cx_new;
            cy_reg <= cy_new;
            hw_reg <= hw_new;
            hh_reg <= hh_new;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg  <= in_px;
            py_reg  <= in_py;
            dx_reg  <= obbpq_pkg::DIFF_W'(in_px) - obbpq_pkg::DIFF_W'(cx_reg);
            dy_reg  <= obbpq_pkg::DIFF_W'(in_py) - obbpq_pkg::DIFF_W'(cy_reg);
            sat_reg <= 1'b0;
        end else if (cmd.ld_upd) begin
            sat_reg <= ovf_cx | ovf_cy | ovf_hw | ovf_hh;
        end
        if (cmd.ld_pi) begin
            pi_reg <= dot_res[obbpq_pkg::PROJ_W-1:0];
        end
        if (cmd.ld_pj) begin
            pj_reg <= dot_res[obbpq_pkg::PROJ_W-1:0];
        end
        if (cmd.ld_clamp) begin
            ni_reg     <= ni_c;
            nj_reg     <= nj_c;
            inside_reg <= !(pi_lo || pi_hi || pj_lo || pj_hi);
        end
        if (cmd.ld_offx) begin
            offx_reg <= dot_res[obbpq_pkg::NEAR_W-1:0];
        end
        if (cmd.ld_offy) begin
            offy_reg <= dot_res[obbpq_pkg::NEAR_W-1:0];
        end
        if (cmd.ld_gap) begin
            nx_reg <= nx_c;
            ny_reg <= ny_c;
            gx_reg <= diffx[obbpq_pkg::GAP_W:1];
            gy_reg <= diffy[obbpq_pkg::GAP_W:1];
        end
        if (cmd.ld_gi) begin
            gi_reg <= dot_res;
        end
        if (cmd.ld_gj) begin
            gj_reg <= dot_res;
        end
        if (cmd.ld_out) begin
            m_tdata_reg <= {sat_reg, hh_reg, hw_reg, cy_reg, cx_reg,
                            near_y, near_x, inside_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.grow     = grow_reg && !inside_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

@@ hdl/obbpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// obbpq_ctrl
// Sequencer: walks one point through projection, clamp, nearest point and
// the optional grow, then hands the result to the output register.
// ----------------------------------------------------------------------------
module obbpq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  obbpq_pkg::status_t    status,
    output obbpq_pkg::cmd_t       cmd
);

    obbpq_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= obbpq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            obbpq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = obbpq_pkg::ST_PI;
                end
            end
            obbpq_pkg::ST_PI:    state_next = obbpq_pkg::ST_PJ;
            obbpq_pkg::ST_PJ:    state_next = obbpq_pkg::ST_CLAMP;
            obbpq_pkg::ST_CLAMP: state_next = obbpq_pkg::ST_NX;
            obbpq_pkg::ST_NX:    state_next = obbpq_pkg::ST_NY;
            obbpq_pkg::ST_NY:    state_next = obbpq_pkg::ST_GAP;
            obbpq_pkg::ST_GAP: begin
                state_next = status.grow ? obbpq_pkg::ST_GI : obbpq_pkg::ST_OUT;
            end
            obbpq_pkg::ST_GI:    state_next = obbpq_pkg::ST_GJ;
            obbpq_pkg::ST_GJ:    state_next = obbpq_pkg::ST_UPD;
            obbpq_pkg::ST_UPD:   state_next = obbpq_pkg::ST_OUT;
            obbpq_pkg::ST_OUT: begin
                if (!status.out_busy) begin
                    state_next = obbpq_pkg::ST_IDLE;
                end
            end
            default: state_next = obbpq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        cmd.dot_op = obbpq_pkg::DOT_PI;
        case (state_reg)
            obbpq_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            obbpq_pkg::ST_PI: begin
                cmd.dot_op = obbpq_pkg::DOT_PI;
                cmd.ld_pi  = 1'b1;
            end
            obbpq_pkg::ST_PJ: begin
                cmd.dot_op = obbpq_pkg::DOT_PJ;
                cmd.ld_pj  = 1'b1;
            end
            obbpq_pkg::ST_CLAMP: begin
                cmd.ld_clamp = 1'b1;
            end
            obbpq_pkg::ST_NX: begin
                cmd.dot_op  = obbpq_pkg::DOT_NX;
                cmd.ld_offx = 1'b1;
            end
            obbpq_pkg::ST_NY: begin
                cmd.dot_op  = obbpq_pkg::DOT_NY;
                cmd.ld_offy = 1'b1;
            end
            obbpq_pkg::ST_GAP: begin
                cmd.ld_gap = 1'b1;
            end
            obbpq_pkg::ST_GI: begin
                cmd.dot_op = obbpq_pkg::DOT_GI;
                cmd.ld_gi  = 1'b1;
            end
            obbpq_pkg::ST_GJ: begin
                cmd.dot_op = obbpq_pkg::DOT_GJ;
                cmd.ld_gj  = 1'b1;
            end
            obbpq_pkg::ST_UPD: begin
                cmd.ld_upd = 1'b1;
            end
            obbpq_pkg::ST_OUT: begin
                cmd.ld_out = !status.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/obb_point_query_and_grow_unit.sv @@
// ----------------------------------------------------------------------------
// obb_point_query_and_grow_unit
// Oriented 2D box: inside test, nearest point on the box and optional grow.
// ----------------------------------------------------------------------------
// one point at a time: a new point is taken only once the last result is in
//   the output register; the steps take turns on the single shared rotation
//   unit (two multipliers), which each rotation step uses once
// reset: box center and extents cleared, axis set to (1.0, 0), grow off
// the output register holds a finished result while the next point is taken
// ----------------------------------------------------------------------------
module obb_point_query_and_grow_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [obbpq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [obbpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y
    input  logic [obbpq_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // is_inside, nearest_x, nearest_y, box_center_x, box_center_y,
    // box_half_width, box_half_height, saturated
    output logic [obbpq_pkg::OUT_DATA_W-1:0]     m_tdata
);

    obbpq_pkg::cmd_t    cmd;
    obbpq_pkg::status_t status;

    obbpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    obbpq_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/sv/obb_box_monitor.sv @@
// ----------------------------------------------------------------------------
// obb_box_monitor
// Watches the point and result streams and the register port of the oriented
// box unit. It keeps its own copy of the box, predicts every result beat and
// compares the result beats field by field, in order.
// ----------------------------------------------------------------------------
module obb_box_monitor
    import obbpq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    answers_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // result beat, lowest field last
    typedef struct packed {
        logic                       saturated;
        logic [HALF_W-1:0]          half_height;
        logic [HALF_W-1:0]          half_width;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  nearest_y;
        logic signed [COORD_W-1:0]  nearest_x;
        logic                       is_inside;
    } box_answer_t;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint U31_MAX = 64'sd2147483647;

    logic signed [COORD_W-1:0] cx_now, cy_now;
    logic [HALF_W-1:0]         hw_now, hh_now;
    logic signed [AXIS_W-1:0]  axis_c, axis_s;
    logic                      grow_en;
    box_answer_t               box_answers[$];
    int                        bad = 0;

    function automatic longint clamp_to(input longint v, input longint lo,
                                        input longint hi, inout bit hit);
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // one point through the box, updating the working box when it grows
    function automatic box_answer_t query_box(input logic signed [COORD_W-1:0] pt_x,
                                              input logic signed [COORD_W-1:0] pt_y);
        longint c, s, px, py, dx, dy, li, lj, hw, hh;
        longint ni, nj, nx, ny, gx, gy, gi, gj;
        bit in_box, sat, clipped;
        box_answer_t ans;
        c  = longint'(axis_c);
        s  = longint'(axis_s);
        px = longint'(pt_x);
        py = longint'(pt_y);
        hw = longint'(hw_now);
        hh = longint'(hh_now);
        dx = px - longint'(cx_now);
        dy = py - longint'(cy_now);
        li = (dx * c + dy * s) >>> AXIS_FRAC;
        lj = (dy * c - dx * s) >>> AXIS_FRAC;
        in_box = li >= -hw && li <= hw && lj >= -hh && lj <= hh;
        clipped = 1'b0;
        ni = clamp_to(li, -hw, hw, clipped);
        nj = clamp_to(lj, -hh, hh, clipped);
        nx = longint'(cx_now) + ((ni * c - nj * s) >>> AXIS_FRAC);
        ny = longint'(cy_now) + ((ni * s + nj * c) >>> AXIS_FRAC);
        sat = 1'b0;
        if (grow_en && !in_box) begin
            // half gap taken from the nearest point before it is clipped to 32 bits
            gx = (px - nx) >>> 1;
            gy = (py - ny) >>> 1;
            gi = (gx * c + gy * s) >>> AXIS_FRAC;
            gj = (gy * c - gx * s) >>> AXIS_FRAC;
            cx_now = COORD_W'(clamp_to(longint'(cx_now) + gx, S32_MIN, S32_MAX, sat));
            cy_now = COORD_W'(clamp_to(longint'(cy_now) + gy, S32_MIN, S32_MAX, sat));
            hw_now = HALF_W'(clamp_to(hw + (gi < 0 ? -gi : gi), 0, U31_MAX, sat));
            hh_now = HALF_W'(clamp_to(hh + (gj < 0 ? -gj : gj), 0, U31_MAX, sat));
        end
        ans.is_inside   = in_box;
        ans.nearest_x   = COORD_W'(clamp_to(nx, S32_MIN, S32_MAX, clipped));
        ans.nearest_y   = COORD_W'(clamp_to(ny, S32_MIN, S32_MAX, clipped));
        ans.center_x    = cx_now;
        ans.center_y    = cy_now;
        ans.half_width  = hw_now;
        ans.half_height = hh_now;
        ans.saturated   = sat;
        return ans;
    endfunction

    always @(posedge aclk) begin : watch
        box_answer_t got, want;
        if (!aresetn) begin
            cx_now  = '0;
            cy_now  = '0;
            hw_now  = '0;
            hh_now  = '0;
            axis_c  = AXIS_COS_RST;
            axis_s  = '0;
            grow_en = 1'b0;
            box_answers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = box_answer_t'(m_tdata);
                if (box_answers.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
                end else begin
                    want = box_answers.pop_front();
                    if (got.is_inside !== want.is_inside
                            || got.nearest_x !== want.nearest_x
                            || got.nearest_y !== want.nearest_y
                            || got.center_x !== want.center_x
                            || got.center_y !== want.center_y
                            || got.half_width !== want.half_width
                            || got.half_height !== want.half_height
                            || got.saturated !== want.saturated) begin
                        bad++;
                        if (bad <= 10) begin
                            $display("%0t: mismatch, expected / actual:", $time);
                            $display("  inside %b/%b  nearest %h,%h / %h,%h",
                                     want.is_inside, got.is_inside,
                                     want.nearest_x, want.nearest_y,
                                     got.nearest_x, got.nearest_y);
                            $display("  center %h,%h / %h,%h  half %h,%h / %h,%h  sat %b/%b",
                                     want.center_x, want.center_y,
                                     got.center_x, got.center_y,
                                     want.half_width, want.half_height,
                                     got.half_width, got.half_height,
                                     want.saturated, got.saturated);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                box_answers.push_back(query_box(s_tdata[COORD_W-1:0],
                                                s_tdata[2*COORD_W-1:COORD_W]));
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CENTER_X:    cx_now  = cfg_wdata[COORD_W-1:0];
                    REG_CENTER_Y:    cy_now  = cfg_wdata[COORD_W-1:0];
                    REG_HALF_WIDTH:  hw_now  = cfg_wdata[HALF_W-1:0];
                    REG_HALF_HEIGHT: hh_now  = cfg_wdata[HALF_W-1:0];
                    REG_AXIS_COS:    axis_c  = cfg_wdata[AXIS_W-1:0];
                    REG_AXIS_SIN:    axis_s  = cfg_wdata[AXIS_W-1:0];
                    REG_GROW_EN:     grow_en = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        fail_count  <= bad;
        answers_due <= box_answers.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives points and register writes into the oriented box unit with random
// gaps and result stalls: a directed set of corner cases, then random boxes
// with mostly nearby points. The box monitor predicts and checks every beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import obbpq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_POINTS = 93;
    // past the last register, writes here are dropped
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int          fail_count;
    int          answers_due;
    int unsigned cycle_count = 0;
    bit          calm_in     = 1'b0;
    bit          calm_out    = 1'b0;

    logic signed [COORD_W-1:0] base_x = '0, base_y = '0;

    obb_point_query_and_grow_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    obb_box_monitor monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .answers_due (answers_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL obb_point_query_and_grow_unit");
            $finish;
        end
    end

    // result side: random stall before each beat
    initial begin : drain
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm_out ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every point has its result beat back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_due != 0) @(posedge aclk);
    endtask

    // unused upper bits of the write data carry noise, the block drops them
    task automatic load_box(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [HALF_W-1:0] hw, input logic [HALF_W-1:0] hh,
                            input logic [AXIS_W-1:0] c, input logic [AXIS_W-1:0] s,
                            input logic grow);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_HALF_WIDTH, {1'($urandom), hw});
        write_reg(REG_HALF_HEIGHT, {1'($urandom), hh});
        write_reg(REG_AXIS_COS, {16'($urandom), c});
        write_reg(REG_AXIS_SIN, {16'($urandom), s});
        write_reg(REG_GROW_EN, {31'($urandom), grow});
        base_x = cx;
        base_y = cy;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom;
            2:       return $signed($urandom) >>> 11;
            3:       return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] pick_extent();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return HALF_W'($urandom_range(0, 1 << 20));
            2:       return 31'h7FFF_FFFF;
            3:       return 31'($urandom);
            default: return HALF_W'($urandom_range(1, 1 << 24));
        endcase
    endfunction

    task automatic pick_box();
        logic signed [AXIS_W-1:0] c, s;
        case ($urandom_range(0, 8))
            0: begin c = 16'sd16384;  s = 16'sd0;      end
            1: begin c = 16'sd0;      s = 16'sd16384;  end
            2: begin c = -16'sd16384; s = 16'sd0;      end
            3: begin c = 16'sd0;      s = -16'sd16384; end
            4: begin c = 16'sd11585;  s = 16'sd11585;  end
            5: begin c = -16'sd11585; s = 16'sd11585;  end
            6: begin c = 16'sd14189;  s = -16'sd8192;  end
            7: begin
                // not a unit vector, used as written
                c = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
                s = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
            end
            default: begin
                c = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                s = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            end
        endcase
        load_box(pick_coord(), pick_coord(), pick_extent(), pick_extent(), c, s,
                 $urandom_range(0, 4) < 3);
    endtask

    initial begin : stimulus
        logic signed [COORD_W-1:0] px, py;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // box left at reset: zero size at the origin
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        // axis aligned box, points on each edge and just past two of them
        load_box(32'h0, 32'h0, 31'h1_0000, 31'h8000, 16'sd16384, 16'sd0, 1'b0);
        send_point(32'h0001_0000, 32'h0000_0000);
        send_point(32'h0001_0001, 32'h0000_0000);
        send_point(32'h0000_0000, 32'hFFFF_8000);
        send_point(32'hFFFF_0000, 32'h0000_8000);
        send_point(32'h0000_0000, 32'h0000_8001);
        settle();

        // rotated box that grows toward outside points
        load_box(32'h0002_0000, 32'hFFFE_0000, 31'h4000, 31'h4000,
                 16'sd11585, 16'sd11585, 1'b1);
        send_point(32'h0010_0000, 32'h0010_0000);
        send_point(32'hFFF0_0000, 32'h0000_0000);
        send_point(32'h0002_0000, 32'hFFFE_0000);
        send_point(32'h0010_0000, 32'h0010_0000);
        settle();

        // full size box at the range corner, non-unit axis, growing
        load_box(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 16'sd16384, 16'sd16384, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h0000_0000, 32'h0000_0000);
        settle();

        load_box(32'h8000_0000, 32'h8000_0000, 31'h0, 31'h0, -16'sd16384, -16'sd16384, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        settle();
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_point(32'h0000_0000, 32'h0000_0000);
        settle();

        load_box(32'h0, 32'h0, 31'h7FFF_FFFF, 31'h0, 16'sd0, -16'sd16384, 1'b0);
        send_point(32'h1234_5678, 32'h9ABC_DEF0);
        send_point(32'h0000_0000, 32'h0000_0000);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            pick_box();
            calm_in  = $urandom_range(0, 3) == 0;
            calm_out = $urandom_range(0, 3) == 0;
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    px = $urandom;
                    py = $urandom;
                end else begin
                    px = base_x + ($signed($urandom) >>> $urandom_range(1, 31));
                    py = base_y + ($signed($urandom) >>> $urandom_range(1, 31));
                end
                send_point(px, py);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && answers_due == 0) begin
            $display("PASS obb_point_query_and_grow_unit");
        end else begin
            $display("FAIL obb_point_query_and_grow_unit");
        end
        $finish;
    end

endmodule
